### rtl/free_index_stack_allocator_defines.svh
// Assertion macros shared by the free index stack allocator RTL.
// Expects clk_i and rst_ni to be visible in the module that uses them.
`ifndef FREE_INDEX_STACK_ALLOCATOR_DEFINES_SVH
`define FREE_INDEX_STACK_ALLOCATOR_DEFINES_SVH

// Property that must hold on every clock edge outside reset.
`define FISA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FISA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/fisa_pkg.sv
// Package for the free index stack allocator: field widths, codes and types.
// Used by every module of the block; depends on nothing.
package fisa_pkg;

  localparam int DEF_POOL_SIZE = 256;
  localparam int IDX_W         = 8;
  localparam int STATUS_W      = 2;
  localparam int COUNT_W       = 9;

  typedef enum logic {
    OP_RESERVE = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_DOUBLE = 2'd2
  } status_e;

  // Shift command broadcast to every stack cell.
  typedef struct packed {
    logic push;
    logic pop;
  } stack_ctrl_t;

endpackage

### rtl/fisa_cell.sv
// One entry of the shifting free-index stack.
// Depends on fisa_pkg for the shift command type.
module fisa_cell #(
  parameter int DATA_W      = 8,
  parameter int RESET_VALUE = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fisa_pkg::stack_ctrl_t ctrl_i,
  input  logic [DATA_W-1:0]    above_i,
  input  logic [DATA_W-1:0]    below_i,
  output logic [DATA_W-1:0]    data_o
);

  logic [DATA_W-1:0] data_q;
  logic [DATA_W-1:0] data_d;

  // A push moves entries away from the top, a pop moves them toward it.
  always_comb begin
    data_d = data_q;
    if (ctrl_i.push) begin
      data_d = above_i;
    end else if (ctrl_i.pop) begin
      data_d = below_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= DATA_W'(RESET_VALUE);
    end else begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

### rtl/fisa_free_map.sv
// Bitmap of free slots for the slots that a release can name.
// Depends on fisa_pkg for the index width.
module fisa_free_map #(
  parameter int POOL_SIZE = fisa_pkg::DEF_POOL_SIZE,
  parameter int CELL_W    = $clog2(POOL_SIZE)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       set_i,
  input  logic [fisa_pkg::IDX_W-1:0] set_idx_i,
  input  logic                       clr_i,
  input  logic [CELL_W-1:0]          clr_idx_i,
  output logic                       slot_busy_o
);

  localparam int MAP_N = (POOL_SIZE < (1 << fisa_pkg::IDX_W)) ?
                         POOL_SIZE : (1 << fisa_pkg::IDX_W);
  localparam int MAP_W = $clog2(MAP_N);

  logic [MAP_N-1:0] map_q;
  logic [MAP_N-1:0] map_d;
  logic             in_range;

  // Set the bit of a released slot, clear the bit of a reserved one.
  always_comb begin
    map_d = map_q;
    for (int j = 0; j < MAP_N; j++) begin
      if (set_i && (set_idx_i == fisa_pkg::IDX_W'(j))) begin
        map_d[j] = 1'b1;
      end else if (clr_i && (clr_idx_i == CELL_W'(j))) begin
        map_d[j] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q <= '1;
    end else begin
      map_q <= map_d;
    end
  end

  // A slot outside the pool never counts as in use.
  assign in_range    = ({1'b0, set_idx_i} < (fisa_pkg::IDX_W + 1)'(MAP_N));
  assign slot_busy_o = in_range && !map_q[set_idx_i[MAP_W-1:0]];

endmodule

### rtl/free_index_stack_allocator.sv
// Free index stack allocator, top level: cell chain, depth counter, result register.
// Depends on fisa_pkg, fisa_cell, fisa_free_map and the assertion macro header.
//
// Hands out slot indices from a pool of POOL_SIZE and takes them back, last in,
// first out. After reset every index is free and the highest one is handed out
// first. Each transaction is either a reserve (returns an index, or status empty)
// or a release (status double when the slot is already free or outside the pool;
// such releases change nothing). Unless stalled, one transaction is taken every cycle and
// its result appears in the next cycle: the free list is a row of POOL_SIZE cells
// that all shift by one place in the cycle of the push or pop, so its top is
// always in the first cell. A filled result register that is stalled holds off
// the next transaction; free_count is the number of free indices, kept to 9 bits.
`include "free_index_stack_allocator_defines.svh"

module free_index_stack_allocator #(
  parameter int POOL_SIZE = fisa_pkg::DEF_POOL_SIZE
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          opcode_i,
  input  logic [fisa_pkg::IDX_W-1:0]    slot_index_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [fisa_pkg::IDX_W-1:0]    granted_index_o,
  output logic [fisa_pkg::STATUS_W-1:0] status_o,
  output logic [fisa_pkg::COUNT_W-1:0]  free_count_o
);

  localparam int CELL_W  = $clog2(POOL_SIZE);
  localparam int DEPTH_W = $clog2(POOL_SIZE + 1);

  logic                         accept;
  logic                         is_reserve;
  logic                         reserve_ok;
  logic                         release_ok;
  logic                         slot_busy;
  fisa_pkg::stack_ctrl_t        ctrl;
  logic [CELL_W-1:0]            cell_q [POOL_SIZE];
  logic [CELL_W-1:0]            push_head;
  logic [DEPTH_W-1:0]           depth_q;
  logic [DEPTH_W-1:0]           depth_d;
  logic                         out_valid_q;
  logic                         out_valid_d;
  logic [fisa_pkg::IDX_W-1:0]   granted_q;
  logic [fisa_pkg::IDX_W-1:0]   granted_d;
  fisa_pkg::status_e            status_q;
  fisa_pkg::status_e            status_d;
  logic [fisa_pkg::COUNT_W-1:0] count_q;
  logic [fisa_pkg::COUNT_W-1:0] count_d;

  // Handshake: a held result that is stalled blocks the next transaction.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_reserve = (opcode_i == fisa_pkg::OP_RESERVE);

  // Decide whether the transaction touches the free list.
  assign reserve_ok = is_reserve && (depth_q != '0);
  assign release_ok = !is_reserve && slot_busy && (depth_q < DEPTH_W'(POOL_SIZE));
  assign ctrl.pop   = accept && reserve_ok;
  assign ctrl.push  = accept && release_ok;
  assign push_head  = CELL_W'(slot_index_i);

  // Chain of stack cells; cell 0 is the top of the free list.
  for (genvar g = 0; g < POOL_SIZE; g++) begin : g_cell
    logic [CELL_W-1:0] above;
    logic [CELL_W-1:0] below;
    if (g == 0) begin : g_head
      assign above = push_head;
    end else begin : g_mid_up
      assign above = cell_q[g-1];
    end
    if (g == POOL_SIZE - 1) begin : g_tail
      assign below = cell_q[g];
    end else begin : g_mid_down
      assign below = cell_q[g+1];
    end
    fisa_cell #(
      .DATA_W      (CELL_W),
      .RESET_VALUE (POOL_SIZE - 1 - g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .above_i (above),
      .below_i (below),
      .data_o  (cell_q[g])
    );
  end

  fisa_free_map #(
    .POOL_SIZE (POOL_SIZE),
    .CELL_W    (CELL_W)
  ) u_free_map (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .set_i       (ctrl.push),
    .set_idx_i   (slot_index_i),
    .clr_i       (ctrl.pop),
    .clr_idx_i   (cell_q[0]),
    .slot_busy_o (slot_busy)
  );

  // Stack depth follows the pushes and pops.
  always_comb begin
    depth_d = depth_q;
    if (ctrl.pop) begin
      depth_d = depth_q - DEPTH_W'(1);
    end else if (ctrl.push) begin
      depth_d = depth_q + DEPTH_W'(1);
    end
  end

  // Result of the accepted transaction.
  always_comb begin
    granted_d = '0;
    status_d  = fisa_pkg::ST_OK;
    if (is_reserve) begin
      if (reserve_ok) begin
        granted_d = fisa_pkg::IDX_W'(cell_q[0]);
      end else begin
        status_d = fisa_pkg::ST_EMPTY;
      end
    end else if (!release_ok) begin
      status_d = fisa_pkg::ST_DOUBLE;
    end
    count_d = fisa_pkg::COUNT_W'(depth_d);
  end

  // Result register valid: filled on accept, emptied when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= DEPTH_W'(POOL_SIZE);
      out_valid_q <= 1'b0;
    end else begin
      depth_q     <= depth_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      granted_q <= granted_d;
      status_q  <= status_d;
      count_q   <= count_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign granted_index_o = granted_q;
  assign status_o        = status_q;
  assign free_count_o    = count_q;

  // Checks on the depth counter and the result register.
  `FISA_ASSERT_ALWAYS(a_depth_bound, depth_q <= DEPTH_W'(POOL_SIZE), "stack depth beyond pool")
  `FISA_ASSERT_NEXT(a_pop_depth, ctrl.pop, depth_q == $past(depth_q) - DEPTH_W'(1), "pop lost")
  `FISA_ASSERT_NEXT(a_hold_result, out_valid_q && out_stall_i, out_valid_q, "result dropped")
  `FISA_ASSERT_ALWAYS(a_empty_count, !(out_valid_q && status_q == fisa_pkg::ST_EMPTY) || count_q == '0, "empty with free slots")

endmodule

### tb/fisa_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the free index stack allocator: watches both channels, predicts each result.
// Depends on fisa_pkg for the field widths, the operation codes and the status codes.
module fisa_checker #(
  parameter int POOL_SIZE = fisa_pkg::DEF_POOL_SIZE
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic                          opcode_i,
  input  logic [fisa_pkg::IDX_W-1:0]    slot_index_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [fisa_pkg::IDX_W-1:0]    granted_index_i,
  input  logic [fisa_pkg::STATUS_W-1:0] status_i,
  input  logic [fisa_pkg::COUNT_W-1:0]  free_count_i,
  input  logic                          end_of_test_i,
  output int                            fail_count_o
);
  import fisa_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]   granted;
    status_e            status;
    logic [COUNT_W-1:0] count;
  } pool_result_t;

  // Shadow copy of the free list, its depth and the free bitmap.
  int unsigned      shadow_stack [POOL_SIZE];
  logic             slot_free [POOL_SIZE];
  int unsigned      free_depth;
  pool_result_t     pending_results [$];
  bit               end_checked;

  // Applies one reserve or release to the shadow pool and returns its result.
  function automatic pool_result_t apply_pool_op(op_e op, logic [IDX_W-1:0] slot);
    pool_result_t res;
    int unsigned  idx;
    res.granted = '0;
    res.status  = ST_OK;
    if (op == OP_RESERVE) begin
      if (free_depth > 0 && free_depth <= POOL_SIZE) begin
        free_depth--;
        idx = shadow_stack[free_depth];
        if (idx < POOL_SIZE) slot_free[idx] = 1'b0;
        res.granted = IDX_W'(idx);
      end else begin
        res.status = ST_EMPTY;
      end
    end else begin
      // A release that frees nothing leaves the pool untouched.
      if (int'(slot) >= POOL_SIZE || slot_free[slot] || free_depth >= POOL_SIZE) begin
        res.status = ST_DOUBLE;
      end else begin
        shadow_stack[free_depth] = 32'(slot);
        free_depth++;
        slot_free[slot] = 1'b1;
      end
    end
    res.count = COUNT_W'(free_depth);
    return res;
  endfunction

  task automatic report_error(string msg);
    $display("[%0t] allocator check: %s", $realtime, msg);
    fail_count_o++;
  endtask

  // Compares each accepted result against the oldest prediction, then predicts
  // the transaction accepted at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    pool_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < POOL_SIZE; i++) begin
        shadow_stack[i] = i;
        slot_free[i]    = 1'b1;
      end
      free_depth   = POOL_SIZE;
      pending_results.delete();
      fail_count_o = 0;
      end_checked  = 1'b0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_error($sformatf("result with nothing expected (index %0d, status %0d, count %0d)",
                                 granted_index_i, status_i, free_count_i));
        end else begin
          want = pending_results.pop_front();
          if (granted_index_i !== want.granted)
            report_error($sformatf("granted_index got %0d, expected %0d",
                                   granted_index_i, want.granted));
          if (status_i !== want.status)
            report_error($sformatf("status got %0d, expected %0d", status_i, want.status));
          if (free_count_i !== want.count)
            report_error($sformatf("free_count got %0d, expected %0d",
                                   free_count_i, want.count));
        end
      end
      if (in_valid_i && !in_stall_i)
        pending_results.push_back(apply_pool_op(op_e'(opcode_i), slot_index_i));
      if (end_of_test_i && !end_checked) begin
        end_checked = 1'b1;
        if (pending_results.size() != 0)
          report_error($sformatf("%0d results never arrived", pending_results.size()));
      end
    end
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the free index stack allocator: clock, reset, stimulus and verdict.
// Depends on fisa_pkg, the allocator RTL and the fisa_checker scoreboard.
module tb_top;
  import fisa_pkg::*;

  localparam int POOL_SIZE    = DEF_POOL_SIZE;
  localparam int RANDOM_ITEMS = 1330;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                in_valid_i   = 1'b0;
  logic                opcode_i     = 1'b0;
  logic [IDX_W-1:0]    slot_index_i = '0;
  logic                out_stall_i  = 1'b0;
  logic                end_of_test  = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  logic [IDX_W-1:0]    granted_index_o;
  logic [STATUS_W-1:0] status_o;
  logic [COUNT_W-1:0]  free_count_o;
  int                  fail_count;

  // Transaction bookkeeping used only to shape the stimulus.
  int unsigned      sent_total = 0;
  int unsigned      recv_total = 0;
  int unsigned      burst_left = 0;
  op_e              ops_in_flight [$];
  logic [IDX_W-1:0] held_slots [$];

  always #2 clk_i = ~clk_i;

  free_index_stack_allocator #(.POOL_SIZE(POOL_SIZE)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .slot_index_i    (slot_index_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .granted_index_o (granted_index_o),
    .status_o        (status_o),
    .free_count_o    (free_count_o)
  );

  fisa_checker #(.POOL_SIZE(POOL_SIZE)) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .opcode_i        (opcode_i),
    .slot_index_i    (slot_index_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .granted_index_i (granted_index_o),
    .status_i        (status_o),
    .free_count_i    (free_count_o),
    .end_of_test_i   (end_of_test),
    .fail_count_o    (fail_count)
  );

  // Tracks which indices the pool has handed out, so releases can target them.
  always @(posedge clk_i) begin
    op_e done_op;
    if (in_valid_i && !in_stall_o) ops_in_flight.push_back(op_e'(opcode_i));
    if (out_valid_o && !out_stall_i) begin
      recv_total <= recv_total + 1;
      done_op = ops_in_flight.pop_front();
      if (done_op == OP_RESERVE && status_o == ST_OK) held_slots.push_back(granted_index_o);
    end
  end

  // Offers one transaction and waits for it to be taken; a burst may end in a random gap.
  task automatic send_op(op_e op, logic [IDX_W-1:0] slot);
    int unsigned gap;
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    slot_index_i <= slot;
    do @(posedge clk_i); while (in_stall_o);
    sent_total++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Holds the input idle until every result sent so far has come back.
  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (recv_total != sent_total);
  endtask

  // Mostly releases an index that is really out; otherwise a random one.
  function automatic logic [IDX_W-1:0] pick_release_slot();
    int unsigned k;
    logic [IDX_W-1:0] slot;
    if (held_slots.size() > 0 && $urandom_range(0, 99) < 85) begin
      k = $urandom_range(0, held_slots.size() - 1);
      slot = held_slots[k];
      held_slots.delete(k);
    end else begin
      slot = IDX_W'($urandom_range(0, 255));
    end
    return slot;
  endfunction

  // Receiver: stretches of different stall patterns, with two long hold-offs.
  initial begin : receiver
    int unsigned hold_at [2];
    int unsigned next_hold;
    int unsigned mode, stretch, n, hold_cycles;
    hold_at   = '{250, 800};
    next_hold = 0;
    forever begin
      if (next_hold < 2 && recv_total >= hold_at[next_hold]) begin
        next_hold++;
        out_stall_i <= 1'b1;
        for (hold_cycles = 0; hold_cycles < 96; hold_cycles++) @(posedge clk_i);
      end
      mode    = $urandom_range(0, 3);
      stretch = $urandom_range(16, 96);
      for (n = 0; n < stretch; n++) begin
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 2) == 0);
          2: out_stall_i <= n[0];
          default: out_stall_i <= ((n % 8) < 3);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    int unsigned k, seg_left;
    bit draining;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: releases of free slots at the field extremes, the highest index
    // handed out first, and a slot given back and then released a second time.
    send_op(OP_RELEASE, 8'd0);
    send_op(OP_RELEASE, 8'd255);
    send_op(OP_RESERVE, 8'd0);
    send_op(OP_RESERVE, 8'd255);
    send_op(OP_RELEASE, 8'd255);
    send_op(OP_RELEASE, 8'd255);
    send_op(OP_RESERVE, 8'hAA);
    send_op(OP_RELEASE, 8'hAA);
    send_op(OP_RELEASE, 8'h55);
    send_op(OP_RELEASE, 8'd254);
    send_op(OP_RELEASE, 8'd255);
    send_op(OP_RELEASE, 8'd128);
    send_op(OP_RESERVE, 8'h55);
    send_op(OP_RELEASE, 8'd255);
    wait_all_results();

    // Random: draining stretches run the pool empty, refill stretches give
    // held indices back, with double releases mixed in as noise.
    draining = 1'b1;
    seg_left = $urandom_range(300, 400);
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (seg_left == 0) begin
        draining = !draining;
        seg_left = draining ? $urandom_range(260, 380) : $urandom_range(150, 300);
      end
      seg_left--;
      if (k == RANDOM_ITEMS / 2) wait_all_results();
      if ($urandom_range(0, 99) < (draining ? 90 : 15))
        send_op(OP_RESERVE, IDX_W'($urandom_range(0, 255)));
      else
        send_op(OP_RELEASE, pick_release_slot());
    end

    wait_all_results();
    repeat (4) @(posedge clk_i);
    end_of_test <= 1'b1;
    repeat (2) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/fisa_pkg.sv
rtl/fisa_cell.sv
rtl/fisa_free_map.sv
rtl/free_index_stack_allocator.sv
tb/fisa_checker.sv
tb/tb_top.sv
